FILE: design/spk_pkg.sv
package spk_pkg;

   localparam int ROUND_COUNT = 26;
   localparam int CNT_W       = $clog2(ROUND_COUNT);
   localparam int WORD_W      = 32;
   localparam int BLOCK_W     = 2 * WORD_W;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CNT_W-1:0] CNT_LAST_ROUND  = CNT_W'(ROUND_COUNT - 1);
   localparam logic [CNT_W-1:0] CNT_LAST_EXPAND = CNT_W'(ROUND_COUNT - 2);

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_2 = 2'd2;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_EXPAND,
      ST_IDLE,
      ST_CRYPT,
      ST_HOLD
   } state_type;

   typedef logic [WORD_W-1:0] word_type;

endpackage

FILE: design/spk_round.sv
module spk_round (
   input  logic                 decrypt,
   input  spk_pkg::word_type    a_word,
   input  spk_pkg::word_type    b_word,
   input  spk_pkg::word_type    round_key,
   output spk_pkg::word_type    a_next,
   output spk_pkg::word_type    b_next
);

   spk_pkg::word_type enc_a;
   spk_pkg::word_type enc_b;
   spk_pkg::word_type dec_a;
   spk_pkg::word_type dec_b;
   spk_pkg::word_type dec_xor;
   spk_pkg::word_type dec_diff;

   // forward round, also used for the key schedule step
   assign enc_a = ({a_word[7:0], a_word[31:8]} + b_word) ^ round_key;
   assign enc_b = {b_word[28:0], b_word[31:29]} ^ enc_a;

   // inverse round
   assign dec_xor  = a_word ^ b_word;
   assign dec_b    = {dec_xor[2:0], dec_xor[31:3]};
   assign dec_diff = (a_word ^ round_key) - dec_b;
   assign dec_a    = {dec_diff[23:0], dec_diff[31:24]};

   assign a_next = decrypt ? dec_a : enc_a;
   assign b_next = decrypt ? dec_b : enc_b;

endmodule

FILE: design/speck64_96_block_cipher.sv
// Operation: a word is accepted in idle and runs 26 rounds, one round per cycle, through
// the single round unit that is shared with the key schedule; req_stall stays high until
// its result is handed to the output register, so no new word is taken before it is through.
// Key schedule: after reset and after each key register write, the round keys are
// expanded through the same round unit before req_stall drops.
// Reset (synchronous, active high) clears the key words to zero and starts expansion.
module speck64_96_block_cipher (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [spk_pkg::BLOCK_W-1:0]     req_data_block,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [spk_pkg::BLOCK_W-1:0]     rsp_result_block,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [spk_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spk_pkg::WORD_W-1:0]      csr_data
);

   spk_pkg::state_type state_ff, state_in;
   logic [spk_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic op_ff, op_in;
   spk_pkg::word_type x_ff, x_in;
   spk_pkg::word_type y_ff, y_in;
   spk_pkg::word_type s0_ff, s0_in;
   spk_pkg::word_type s1_ff, s1_in;
   spk_pkg::word_type key0_ff, key0_in;
   spk_pkg::word_type key1_ff, key1_in;
   spk_pkg::word_type key2_ff, key2_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [spk_pkg::BLOCK_W-1:0] rsp_block_ff, rsp_block_in;

   spk_pkg::word_type rk_ff [spk_pkg::ROUND_COUNT];
   logic rk_we;
   logic [spk_pkg::CNT_W-1:0] rk_waddr;
   spk_pkg::word_type rk_wdata;
   logic [spk_pkg::CNT_W-1:0] rk_raddr;

   logic csr_wr;
   logic key_wr;
   logic out_free;
   logic rnd_decrypt;
   spk_pkg::word_type rnd_a, rnd_k, rnd_a_next, rnd_b_next;

   spk_round u_round (
      .decrypt   (rnd_decrypt),
      .a_word    (rnd_a),
      .b_word    (y_ff),
      .round_key (rnd_k),
      .a_next    (rnd_a_next),
      .b_next    (rnd_b_next)
   );

   assign req_stall = (state_ff != spk_pkg::ST_IDLE);
   // an item arriving in idle wins over a key write
   assign csr_ready = (state_ff == spk_pkg::ST_LOAD) || (state_ff == spk_pkg::ST_EXPAND) ||
                      ((state_ff == spk_pkg::ST_IDLE) && !req_valid);
   assign csr_wr    = csr_valid && csr_ready;
   assign key_wr    = csr_wr && ((csr_index == spk_pkg::CSR_KEY_WORD_0) ||
                                 (csr_index == spk_pkg::CSR_KEY_WORD_1) ||
                                 (csr_index == spk_pkg::CSR_KEY_WORD_2));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_block_ff;

   assign rk_raddr    = (op_ff == spk_pkg::OP_DECRYPT) ? (spk_pkg::CNT_LAST_ROUND - cnt_ff)
                                                        : cnt_ff;
   assign rnd_decrypt = (state_ff == spk_pkg::ST_CRYPT) && (op_ff == spk_pkg::OP_DECRYPT);
   always_comb begin
      if (state_ff == spk_pkg::ST_EXPAND) begin
         rnd_a = cnt_ff[0] ? s1_ff : s0_ff;
         rnd_k = spk_pkg::WORD_W'(cnt_ff);
      end else begin
         rnd_a = x_ff;
         rnd_k = rk_ff[rk_raddr];
      end
   end

   always_comb begin
      key0_in = key0_ff;
      key1_in = key1_ff;
      key2_in = key2_ff;
      if (csr_wr) begin
         unique case (csr_index)
            spk_pkg::CSR_KEY_WORD_0: key0_in = csr_data;
            spk_pkg::CSR_KEY_WORD_1: key1_in = csr_data;
            spk_pkg::CSR_KEY_WORD_2: key2_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_block_in = rsp_block_ff;
      rk_we        = 1'b0;
      rk_waddr     = cnt_ff + 1'b1;
      rk_wdata     = rnd_b_next;
      unique case (state_ff)
         spk_pkg::ST_LOAD: begin
            y_in     = key0_ff;
            s0_in    = key1_ff;
            s1_in    = key2_ff;
            cnt_in   = '0;
            rk_we    = 1'b1;
            rk_waddr = '0;
            rk_wdata = key0_ff;
            state_in = spk_pkg::ST_EXPAND;
         end
         spk_pkg::ST_EXPAND: begin
            if (cnt_ff[0]) begin
               s1_in = rnd_a_next;
            end else begin
               s0_in = rnd_a_next;
            end
            y_in   = rnd_b_next;
            rk_we  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == spk_pkg::CNT_LAST_EXPAND) begin
               state_in = spk_pkg::ST_IDLE;
            end
         end
         spk_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               x_in     = req_data_block[spk_pkg::BLOCK_W-1:spk_pkg::WORD_W];
               y_in     = req_data_block[spk_pkg::WORD_W-1:0];
               cnt_in   = '0;
               state_in = spk_pkg::ST_CRYPT;
            end
         end
         spk_pkg::ST_CRYPT: begin
            x_in   = rnd_a_next;
            y_in   = rnd_b_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == spk_pkg::CNT_LAST_ROUND) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_block_in = {rnd_a_next, rnd_b_next};
                  state_in     = spk_pkg::ST_IDLE;
               end else begin
                  state_in = spk_pkg::ST_HOLD;
               end
            end
         end
         spk_pkg::ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_block_in = {x_ff, y_ff};
               state_in     = spk_pkg::ST_IDLE;
            end
         end
         default: state_in = spk_pkg::ST_LOAD;
      endcase
      // new key: restart the schedule
      if (key_wr) begin
         state_in = spk_pkg::ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spk_pkg::ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         key0_ff      <= '0;
         key1_ff      <= '0;
         key2_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         key0_ff      <= key0_in;
         key1_ff      <= key1_in;
         key2_ff      <= key2_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      s0_ff        <= s0_in;
      s1_ff        <= s1_in;
      rsp_block_ff <= rsp_block_in;
   end

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_ff[rk_waddr] <= rk_wdata;
      end
   end

   a_accept_starts_rounds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == spk_pkg::ST_CRYPT) && (cnt_ff == '0))
      else $error("accepted word did not start the round sequence");

   a_key_write_reloads: assert property (@(posedge clock) disable iff (reset)
      key_wr |=> (state_ff == spk_pkg::ST_LOAD))
      else $error("key write did not restart the schedule");

   a_rsp_from_rounds: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (($past(state_ff) == spk_pkg::ST_CRYPT) ||
                               ($past(state_ff) == spk_pkg::ST_HOLD)))
      else $error("result word raised outside the round sequence");

   a_expand_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spk_pkg::ST_EXPAND) |-> (cnt_ff <= spk_pkg::CNT_LAST_EXPAND))
      else $error("schedule step counter overran");

   a_hold_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spk_pkg::ST_HOLD) |-> rsp_valid_ff)
      else $error("holding a result with the output register empty");

endmodule
